// File: sv/tsp_pkg.sv
`default_nettype none
package tsp_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int CORDIC_N      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

   localparam int ACC_W   = 16;
   localparam int SQ_W    = 32;
   localparam int FRAC_W  = 16;
   localparam int RAD_W   = SQ_W + FRAC_W;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int TAG_W   = ACC_W + 1;
   localparam int XY_W    = 28;
   localparam int Z_W     = 25;
   localparam int ANG_W   = 12;
   localparam int PULSE_W = 12;
   localparam int CSR_W   = 12;
   localparam int DZ_W    = 11;

   localparam int ANGLE_LIMIT = 1440;
   localparam int SPAN_180    = 2880;

   typedef enum logic [2:0] {
      CSR_DEAD_ZONE  = 3'd0,
      CSR_ALERT_THR  = 3'd1,
      CSR_STOP_PULSE = 3'd2,
      CSR_MIN_PULSE  = 3'd3,
      CSR_MAX_PULSE  = 3'd4
   } csr_index_type;

   // atan(2^-i) in degrees * 65536, rounded
   function automatic logic [Z_W-1:0] atan_entry(input int i);
      logic [Z_W-1:0] v;
      unique case (i)
         0:  v = Z_W'(2949120);
         1:  v = Z_W'(1740967);
         2:  v = Z_W'(919879);
         3:  v = Z_W'(466945);
         4:  v = Z_W'(234379);
         5:  v = Z_W'(117304);
         6:  v = Z_W'(58666);
         7:  v = Z_W'(29335);
         8:  v = Z_W'(14668);
         9:  v = Z_W'(7334);
         10: v = Z_W'(3667);
         11: v = Z_W'(1833);
         12: v = Z_W'(917);
         13: v = Z_W'(458);
         14: v = Z_W'(229);
         15: v = Z_W'(115);
         16: v = Z_W'(57);
         17: v = Z_W'(29);
         18: v = Z_W'(14);
         19: v = Z_W'(7);
         20: v = Z_W'(4);
         21: v = Z_W'(2);
         22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: sv/tsp_sqrt.sv
`default_nettype none
module tsp_sqrt (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic [tsp_pkg::SQ_W-1:0]           in_sq,
   input  wire logic signed [tsp_pkg::TAG_W-1:0]   in_tag,
   output logic                                    out_valid,
   output logic [tsp_pkg::ROOT_W-1:0]              out_root,
   output logic signed [tsp_pkg::TAG_W-1:0]        out_tag
);

   localparam int RW = tsp_pkg::RAD_W;
   localparam int QW = tsp_pkg::ROOT_W;

   logic [RW-1:0]                      rem_ff  [0:QW];
   logic [QW-1:0]                      root_ff [0:QW];
   logic signed [tsp_pkg::TAG_W-1:0]   tag_ff  [0:QW];
   logic                               valid_ff[0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= {in_sq, {tsp_pkg::FRAC_W{1'b0}}};
         root_ff[0] <= '0;
         tag_ff[0]  <= in_tag;
      end
   end

   // one root bit per stage, msb first
   for (genvar k = 0; k < QW; k++) begin : g_bit
      localparam int I = QW - 1 - k;
      logic [RW-1:0] trial;
      assign trial = (RW'(root_ff[k]) << (I + 1)) | (RW'(1) << (2 * I));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (en) begin
            tag_ff[k+1] <= tag_ff[k];
            if (rem_ff[k] >= trial) begin
               rem_ff[k+1]  <= rem_ff[k] - trial;
               root_ff[k+1] <= root_ff[k] | (QW'(1) << I);
            end else begin
               rem_ff[k+1]  <= rem_ff[k];
               root_ff[k+1] <= root_ff[k];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_root  = root_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule
`default_nettype wire

// File: sv/tsp_cordic.sv
`default_nettype none
module tsp_cordic (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic [tsp_pkg::ROOT_W-1:0]         in_root,
   input  wire logic signed [tsp_pkg::TAG_W-1:0]   in_tag,
   output logic                                    out_valid,
   output logic                                    out_zero,
   output logic signed [tsp_pkg::Z_W-1:0]          out_angle
);

   localparam int N  = tsp_pkg::CORDIC_N;
   localparam int XW = tsp_pkg::XY_W;
   localparam int ZW = tsp_pkg::Z_W;

   logic signed [XW-1:0] x_ff    [0:N];
   logic signed [XW-1:0] y_ff    [0:N];
   logic signed [ZW-1:0] z_ff    [0:N];
   logic                 zero_ff [0:N];
   logic                 valid_ff[0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= $signed(XW'(in_root));
         // y starts as -accel_x scaled by 2^8
         y_ff[0]    <= XW'(in_tag) <<< 8;
         z_ff[0]    <= '0;
         zero_ff[0] <= (in_root == '0) && (in_tag == '0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [ZW-1:0] step;
      assign dx   = y_ff[i] >>> i;
      assign dy   = x_ff[i] >>> i;
      assign step = $signed(tsp_pkg::atan_entry(i));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (en) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][XW-1]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end
         end
      end
   end

   assign out_valid = valid_ff[N];
   assign out_zero  = zero_ff[N];
   assign out_angle = z_ff[N];

endmodule
`default_nettype wire

// File: sv/tilt_to_servo_pulse.sv
`default_nettype none
// Tilt to servo pulse: each accelerometer request gives one response holding the
// pitch angle atan2(-x, sqrt(y^2+z^2)) in degrees*16, a servo pulse width in us,
// a servo-active flag and an alert flag. Fully pipelined: one request per cycle
// when not stalled, through the squares register, the square root (one bit per
// stage), the CORDIC and stages p1 to p4. The whole pipe stalls while a response
// waits on rsp_ready. CSR writes are taken any time but must only happen while idle.
module tilt_to_servo_pulse (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [tsp_pkg::ACC_W-1:0]   req_accel_x,
   input  wire logic signed [tsp_pkg::ACC_W-1:0]   req_accel_y,
   input  wire logic signed [tsp_pkg::ACC_W-1:0]   req_accel_z,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [tsp_pkg::ANG_W-1:0]        rsp_tilt_angle,
   output logic [tsp_pkg::PULSE_W-1:0]             rsp_pulse_width,
   output logic                                    rsp_servo_active,
   output logic                                    rsp_alert,
   input  wire logic                               csr_we,
   input  wire logic [2:0]                         csr_addr,
   input  wire logic [tsp_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int PW = tsp_pkg::PULSE_W;
   localparam int AW = tsp_pkg::ANG_W;
   localparam int DW = tsp_pkg::DZ_W;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // csr
   logic [DW-1:0] dead_zone_ff, alert_thr_ff;
   logic [PW-1:0] stop_ff, min_ff, max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DW'(80);
         alert_thr_ff <= DW'(720);
         stop_ff      <= PW'(1500);
         min_ff       <= PW'(500);
         max_ff       <= PW'(2500);
      end else if (csr_we) begin
         unique case (csr_addr)
            tsp_pkg::CSR_DEAD_ZONE:  dead_zone_ff <= csr_wdata[DW-1:0];
            tsp_pkg::CSR_ALERT_THR:  alert_thr_ff <= csr_wdata[DW-1:0];
            tsp_pkg::CSR_STOP_PULSE: stop_ff      <= csr_wdata;
            tsp_pkg::CSR_MIN_PULSE:  min_ff       <= csr_wdata;
            tsp_pkg::CSR_MAX_PULSE:  max_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // squares
   logic                               s0_valid_ff;
   logic [31:0]                        ysq_ff, zsq_ff;
   logic signed [tsp_pkg::TAG_W-1:0]   negx_ff;
   logic signed [31:0]                 ysq_in, zsq_in;

   assign ysq_in = 32'(req_accel_y) * 32'(req_accel_y);
   assign zsq_in = 32'(req_accel_z) * 32'(req_accel_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
      if (en) begin
         ysq_ff  <= $unsigned(ysq_in);
         zsq_ff  <= $unsigned(zsq_in);
         negx_ff <= -($signed({req_accel_x[tsp_pkg::ACC_W-1], req_accel_x}));
      end
   end

   logic                               sq_valid;
   logic [tsp_pkg::ROOT_W-1:0]         sq_root;
   logic signed [tsp_pkg::TAG_W-1:0]   sq_tag;

   tsp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_sq     (ysq_ff + zsq_ff),
      .in_tag    (negx_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   logic                               cd_valid, cd_zero;
   logic signed [tsp_pkg::Z_W-1:0]     cd_angle;

   tsp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_tag    (sq_tag),
      .out_valid (cd_valid),
      .out_zero  (cd_zero),
      .out_angle (cd_angle)
   );

   // p1: round to deg*16 and saturate
   logic [tsp_pkg::Z_W-1:0] zmag;
   logic [12:0]             rnd;
   logic [AW-2:0]           sat;
   logic signed [AW-1:0]    a_in;
   logic                    p1_valid_ff;
   logic signed [AW-1:0]    p1_a_ff;

   assign zmag = cd_angle[tsp_pkg::Z_W-1] ? $unsigned(-cd_angle) : $unsigned(cd_angle);
   assign rnd  = 13'((zmag + tsp_pkg::Z_W'(2048)) >> 12);
   assign sat  = (rnd > 13'(tsp_pkg::ANGLE_LIMIT)) ? (AW-1)'(tsp_pkg::ANGLE_LIMIT)
                                                   : rnd[AW-2:0];
   assign a_in = cd_zero ? '0
               : (cd_angle[tsp_pkg::Z_W-1] ? -$signed({1'b0, sat}) : $signed({1'b0, sat}));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= cd_valid;
      end
      if (en) begin
         p1_a_ff <= a_in;
      end
   end

   // p2: flags and mapping products
   logic [AW-1:0]        apos;
   logic [DW-1:0]        amag;
   logic signed [12:0]   diff;
   logic signed [25:0]   prod_in;
   logic                 p2_valid_ff, p2_active_ff, p2_alert_ff;
   logic signed [AW-1:0] p2_a_ff;
   logic signed [25:0]   p2_prod_ff;
   logic [23:0]          p2_hi_ff;

   assign apos    = AW'(p1_a_ff + AW'(tsp_pkg::ANGLE_LIMIT));
   assign amag    = p1_a_ff[AW-1] ? DW'(-p1_a_ff) : DW'(p1_a_ff);
   assign diff    = $signed({1'b0, min_ff}) - $signed({1'b0, max_ff});
   assign prod_in = 26'($signed({1'b0, apos})) * 26'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p2_a_ff      <= p1_a_ff;
         p2_active_ff <= !(amag < dead_zone_ff);
         p2_alert_ff  <= amag > alert_thr_ff;
         p2_prod_ff   <= prod_in;
         p2_hi_ff     <= 24'(max_ff) * 24'(tsp_pkg::SPAN_180);
      end
   end

   // p3: divide by 2880 as shift by 6 then reciprocal of 45
   localparam logic [18:0] RECIP_45 = 19'd372827;
   logic signed [25:0] num;
   logic [18:0]        nq_in;
   logic               p3_valid_ff, p3_active_ff, p3_alert_ff;
   logic signed [AW-1:0] p3_a_ff;
   logic [18:0]        p3_n_ff;
   logic [37:0]        p3_mul_ff;

   assign num   = $signed({2'b00, p2_hi_ff}) + p2_prod_ff;
   assign nq_in = num[25] ? '0 : num[24:6];

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (en) begin
         p3_a_ff      <= p2_a_ff;
         p3_active_ff <= p2_active_ff;
         p3_alert_ff  <= p2_alert_ff;
         p3_n_ff      <= nq_in;
         p3_mul_ff    <= 38'(nq_in) * 38'(RECIP_45);
      end
   end

   // p4: fix quotient (estimate may be one low), clamp, select
   logic [13:0] q0, q, pc;
   logic [19:0] r;

   assign q0 = p3_mul_ff[37:24];
   assign r  = 20'(p3_n_ff) - 20'(q0) * 20'd45;
   assign q  = (r >= 20'd45) ? q0 + 14'd1 : q0;

   always_comb begin
      pc = q;
      if (pc < 14'(min_ff)) pc = 14'(min_ff);
      if (pc > 14'(max_ff)) pc = 14'(max_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (en) begin
         rsp_valid <= p3_valid_ff;
      end
      if (en) begin
         rsp_tilt_angle   <= p3_a_ff;
         rsp_servo_active <= p3_active_ff;
         rsp_alert        <= p3_alert_ff;
         rsp_pulse_width  <= p3_active_ff ? pc[PW-1:0] : stop_ff;
      end
   end

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tilt_angle <= AW'(tsp_pkg::ANGLE_LIMIT))
                 && (rsp_tilt_angle >= -AW'(tsp_pkg::ANGLE_LIMIT)))
      else $error("tilt angle out of range");

   a_pulse_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_servo_active && (min_ff <= max_ff))
         |-> (rsp_pulse_width >= min_ff) && (rsp_pulse_width <= max_ff))
      else $error("pulse outside clamp range");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipe stalled");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (en && cd_valid && cd_zero) |=> (p1_a_ff == '0))
      else $error("zero vector gave nonzero angle");

endmodule
`default_nettype wire
